/* sv/mrp_pkg.sv */
// mrp_pkg: shared constants, types and helpers of the maximal rectangles packer
// no dependencies; imported by the interfaces and the packer module
`default_nettype none
package mrp_pkg;

    localparam int MAX_FREE   = 64;
    localparam int COORD_BITS = 16;
    localparam int FREE_AW    = $clog2(MAX_FREE);
    localparam int SCR_DEPTH  = 4 * MAX_FREE;
    localparam int SCR_AW     = $clog2(SCR_DEPTH);
    localparam int CNT_W      = SCR_AW + 1;
    localparam int TOT_W      = 7;
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int BOX_W      = 4 * COORD_BITS;

    localparam logic [COORD_BITS-1:0] BIN_RESET = COORD_BITS'(1024);

    // configuration register indexes
    localparam logic CFG_BIN_WIDTH  = 1'b0;
    localparam logic CFG_BIN_HEIGHT = 1'b1;

    // request actions
    localparam logic ACT_PLACE   = 1'b0;
    localparam logic ACT_NEW_BIN = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_box;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SC_RD,
        ST_SC_CK,
        ST_SP_RD,
        ST_SP_LAT,
        ST_SP_WR,
        ST_PR_IRD,
        ST_PR_ILAT,
        ST_PR_JRD,
        ST_PR_JCK,
        ST_PR_WR,
        ST_EM_RD,
        ST_EM_LAT,
        ST_EM_CK,
        ST_EM_GET,
        ST_EM_WR,
        ST_DONE
    } t_state;

    function automatic logic box_holds(t_box outer, t_box inner);
        return outer.x0 <= inner.x0 && outer.y0 <= inner.y0 &&
               inner.x1 <= outer.x1 && inner.y1 <= outer.y1;
    endfunction

    function automatic logic box_same(t_box a, t_box b);
        return a == b;
    endfunction

endpackage
`default_nettype wire

/* sv/mrp_req_if.sv */
// mrp_req_if: request channel of the packer (valid/ready plus piece fields)
// depends on mrp_pkg for the coordinate type
`default_nettype none
interface mrp_req_if
    import mrp_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   action;
    t_coord piece_width;
    t_coord piece_height;

    modport source (output valid, action, piece_width, piece_height, input ready);
    modport sink   (input valid, action, piece_width, piece_height, output ready);
endinterface
`default_nettype wire

/* sv/mrp_res_if.sv */
// mrp_res_if: result channel of the packer (valid/ready plus placement fields)
// depends on mrp_pkg for the coordinate type
`default_nettype none
interface mrp_res_if
    import mrp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             placed;
    t_coord           pos_x;
    t_coord           pos_y;
    logic             turned;
    logic [TOT_W-1:0] free_count;
    logic             overflow;

    modport source (output valid, placed, pos_x, pos_y, turned, free_count, overflow,
                    input ready);
    modport sink   (input valid, placed, pos_x, pos_y, turned, free_count, overflow,
                    output ready);
endinterface
`default_nettype wire

/* sv/mrp_ram.sv */
// mrp_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module mrp_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/maximal_rectangles_packer.sv */
// maximal_rectangles_packer: best short side fit packer over a list of maximal free rectangles
// depends on mrp_pkg, mrp_req_if, mrp_res_if and mrp_ram
//
//   channel   dir  handshake            payload
//   i_req     in   valid/ready          action, piece_width, piece_height
//   o_res     out  valid/ready          placed, pos_x, pos_y, turned, free_count, overflow
//   i_cfg_*   in   write enable only    register index, 16 bit data
//
// one transaction at a time: i_req.ready is high only while the sequencer is idle
// place: scan the F free rectangles, split them around the piece into P parts (up to 4*F),
// prune parts held by another part, then sort out the K kept parts, largest area first
// new bin: result is held in the output register until o_res.ready
// synchronous active low reset restores the whole 1024 x 1024 bin, no clearing pass
`default_nettype none
module maximal_rectangles_packer
    import mrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mrp_req_if.sink          i_req,
    mrp_res_if.source        o_res,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);
    t_state r_state, n_state;

    t_coord r_bin_w, r_bin_h, r_whole_w, r_whole_h;
    logic   r_fresh, n_fresh;
    logic [TOT_W-1:0] r_total, n_total;
    t_coord r_pw, n_pw, r_ph, n_ph;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j, r_n, n_n;
    logic [1:0] r_p, n_p;
    logic   r_found, n_found;
    t_coord r_best, n_best, r_bw, n_bw, r_bh, n_bh, r_px, n_px, r_py, n_py;
    t_coord r_qx, n_qx, r_qy, n_qy;
    logic   r_bt, n_bt;
    t_box   r_f, n_f, r_bi, n_bi;
    logic   r_drop, n_drop;
    logic [AREA_W-1:0] r_area, n_area, r_best_area, n_best_area;
    logic   r_mk, n_mk;
    logic [SCR_AW-1:0] r_best_idx, n_best_idx;
    logic   r_have, n_have;
    logic [TOT_W-1:0] r_kept, n_kept;
    logic   r_lost, n_lost;

    logic   r_placed, n_placed, r_turned, n_turned, r_ovf, n_ovf;
    t_coord r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [TOT_W-1:0] r_count, n_count;

    // ram ports
    logic              f_we;
    logic [FREE_AW-1:0] f_waddr, f_raddr;
    logic [BOX_W-1:0]  f_wdata, f_rdata;
    logic              s_we;
    logic [SCR_AW-1:0] s_waddr, s_raddr;
    logic [BOX_W-1:0]  s_wdata, s_rdata;
    logic              m_we, m_wdata, m_rdata;
    logic [SCR_AW-1:0] m_waddr, m_raddr;

    mrp_ram #(.DATA_W(BOX_W), .DEPTH(MAX_FREE)) u_free (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));
    mrp_ram #(.DATA_W(BOX_W), .DEPTH(SCR_DEPTH)) u_scratch (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));
    mrp_ram #(.DATA_W(1), .DEPTH(SCR_DEPTH)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));

    // after a new bin only entry zero is live and it is held in registers
    t_box f_box, s_box, whole;
    assign whole = '{x0: '0, y0: '0, x1: r_whole_w, y1: r_whole_h};
    assign f_box = r_fresh ? whole : t_box'(f_rdata);
    assign s_box = t_box'(s_rdata);

    // fit test of one free rectangle, unturned then turned
    t_coord fw, fh, wu, wt, best1;
    logic   fit_u, fit_t, c1, c2, found1;
    always_comb begin
        fw     = f_box.x1 - f_box.x0;
        fh     = f_box.y1 - f_box.y0;
        fit_u  = r_pw <= fw && r_ph <= fh;
        fit_t  = r_ph <= fw && r_pw <= fh;
        wu     = (fw - r_pw) < (fh - r_ph) ? fw - r_pw : fh - r_ph;
        wt     = (fw - r_ph) < (fh - r_pw) ? fw - r_ph : fh - r_pw;
        c1     = fit_u && (!r_found || wu < r_best);
        best1  = c1 ? wu : r_best;
        found1 = r_found || c1;
        c2     = fit_t && (!found1 || wt < best1);
    end

    // split of one free rectangle around the piece
    logic   ovl, part_ok;
    t_coord ix0, iy0, ix1, iy1;
    t_box   part;
    always_comb begin
        ovl = r_f.x0 < r_qx && r_px < r_f.x1 && r_f.y0 < r_qy && r_py < r_f.y1;
        ix0 = r_f.x0 > r_px ? r_f.x0 : r_px;
        iy0 = r_f.y0 > r_py ? r_f.y0 : r_py;
        ix1 = r_f.x1 < r_qx ? r_f.x1 : r_qx;
        iy1 = r_f.y1 < r_qy ? r_f.y1 : r_qy;
        part    = r_f;
        part_ok = 1'b0;
        if (!ovl) begin
            part_ok = 1'b1;
        end else begin
            case (r_p)
                2'd0: begin
                    part_ok = r_f.y1 > iy1;
                    part.y0 = iy1;
                end
                2'd1: begin
                    part_ok = iy0 > r_f.y0;
                    part.y1 = iy0;
                end
                2'd2: begin
                    part_ok = ix0 > r_f.x0;
                    part.x1 = ix0;
                end
                default: begin
                    part_ok = r_f.x1 > ix1;
                    part.x0 = ix1;
                end
            endcase
        end
    end

    logic prune_hit;
    assign prune_hit = (r_j != r_i) && box_holds(s_box, r_bi) &&
                       (!box_same(s_box, r_bi) || r_j < r_i);

    always_comb begin
        n_state = r_state;
        n_fresh = r_fresh;   n_total = r_total;
        n_pw = r_pw;         n_ph = r_ph;
        n_i = r_i;           n_j = r_j;           n_n = r_n;   n_p = r_p;
        n_found = r_found;   n_best = r_best;     n_bw = r_bw; n_bh = r_bh;
        n_px = r_px;         n_py = r_py;         n_qx = r_qx; n_qy = r_qy;
        n_bt = r_bt;         n_f = r_f;           n_bi = r_bi; n_drop = r_drop;
        n_area = r_area;     n_best_area = r_best_area;       n_mk = r_mk;
        n_best_idx = r_best_idx; n_have = r_have; n_kept = r_kept; n_lost = r_lost;
        n_placed = r_placed; n_turned = r_turned; n_ovf = r_ovf;
        n_pos_x = r_pos_x;   n_pos_y = r_pos_y;   n_count = r_count;

        f_we = 1'b0; f_waddr = r_kept[FREE_AW-1:0]; f_wdata = s_rdata;
        f_raddr = r_i[FREE_AW-1:0];
        s_we = 1'b0; s_waddr = r_n[SCR_AW-1:0]; s_wdata = part;
        s_raddr = r_j[SCR_AW-1:0];
        m_we = 1'b0; m_waddr = r_i[SCR_AW-1:0]; m_wdata = r_drop;
        m_raddr = r_j[SCR_AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_pw = i_req.piece_width;
                    n_ph = i_req.piece_height;
                    n_placed = 1'b0; n_turned = 1'b0; n_ovf = 1'b0;
                    n_pos_x = '0;    n_pos_y = '0;
                    if (i_req.action == ACT_NEW_BIN) begin
                        n_fresh = 1'b1;
                        n_total = TOT_W'(1);
                        n_count = TOT_W'(1);
                        n_state = ST_DONE;
                    end else begin
                        n_i = CNT_W'(r_total);
                        n_found = 1'b0;
                        n_state = ST_SC_RD;
                    end
                end
            end
            ST_SC_RD: begin
                if (r_i == '0) begin
                    if (r_found) begin
                        n_qx = r_px + r_bw;
                        n_qy = r_py + r_bh;
                        n_n = '0;
                        n_state = ST_SP_RD;
                    end else begin
                        n_count = r_total;
                        n_state = ST_DONE;
                    end
                end else begin
                    n_i = r_i - 1'b1;
                    f_raddr = n_i[FREE_AW-1:0];
                    n_state = ST_SC_CK;
                end
            end
            ST_SC_CK: begin
                if (c2) begin
                    n_best = wt; n_bt = 1'b1; n_bw = r_ph; n_bh = r_pw;
                    n_px = f_box.x0; n_py = f_box.y0;
                end else if (c1) begin
                    n_best = wu; n_bt = 1'b0; n_bw = r_pw; n_bh = r_ph;
                    n_px = f_box.x0; n_py = f_box.y0;
                end
                n_found = found1 || c2;
                n_state = ST_SC_RD;
            end
            ST_SP_RD: begin
                if (r_i == CNT_W'(r_total)) begin
                    n_i = '0;
                    n_state = ST_PR_IRD;
                end else begin
                    n_state = ST_SP_LAT;
                end
            end
            ST_SP_LAT: begin
                n_f = f_box;
                n_p = '0;
                n_state = ST_SP_WR;
            end
            ST_SP_WR: begin
                if (part_ok) begin
                    s_we = 1'b1;
                    n_n = r_n + 1'b1;
                end
                if (!ovl || r_p == 2'd3) begin
                    n_i = r_i + 1'b1;
                    n_state = ST_SP_RD;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            ST_PR_IRD: begin
                s_raddr = r_i[SCR_AW-1:0];
                if (r_i == r_n) begin
                    n_j = '0; n_have = 1'b0; n_kept = '0; n_lost = 1'b0;
                    n_state = ST_EM_RD;
                end else begin
                    n_state = ST_PR_ILAT;
                end
            end
            ST_PR_ILAT: begin
                n_bi = s_box;
                n_j = '0;
                n_drop = 1'b0;
                n_state = ST_PR_JRD;
            end
            ST_PR_JRD: begin
                n_state = (r_j == r_n) ? ST_PR_WR : ST_PR_JCK;
            end
            ST_PR_JCK: begin
                if (prune_hit) begin
                    n_drop = 1'b1;
                end
                n_j = r_j + 1'b1;
                n_state = ST_PR_JRD;
            end
            ST_PR_WR: begin
                m_we = 1'b1;
                n_i = r_i + 1'b1;
                n_state = ST_PR_IRD;
            end
            ST_EM_RD: begin
                if (r_j == r_n) begin
                    if (r_have) begin
                        n_state = ST_EM_GET;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_state = ST_EM_LAT;
                end
                if (r_j == r_n && !r_have) begin
                    n_fresh = 1'b0;
                    n_total = r_kept;
                    n_count = r_kept;
                    n_ovf = r_lost;
                    n_placed = 1'b1; n_turned = r_bt;
                    n_pos_x = r_px;  n_pos_y = r_py;
                end
            end
            ST_EM_LAT: begin
                n_area = AREA_W'(s_box.x1 - s_box.x0) * AREA_W'(s_box.y1 - s_box.y0);
                n_mk = m_rdata;
                n_state = ST_EM_CK;
            end
            ST_EM_CK: begin
                // strict compare keeps the earliest of equal areas
                if (!r_mk && (!r_have || r_area > r_best_area)) begin
                    n_have = 1'b1;
                    n_best_area = r_area;
                    n_best_idx = r_j[SCR_AW-1:0];
                end
                n_j = r_j + 1'b1;
                n_state = ST_EM_RD;
            end
            ST_EM_GET: begin
                s_raddr = r_best_idx;
                n_state = ST_EM_WR;
            end
            ST_EM_WR: begin
                if (r_kept == TOT_W'(MAX_FREE)) begin
                    // list full and one more survivor: drop the rest
                    n_fresh = 1'b0;
                    n_total = r_kept;
                    n_count = r_kept;
                    n_ovf = 1'b1;
                    n_placed = 1'b1; n_turned = r_bt;
                    n_pos_x = r_px;  n_pos_y = r_py;
                    n_state = ST_DONE;
                end else begin
                    f_we = 1'b1;
                    m_we = 1'b1;
                    m_waddr = r_best_idx;
                    m_wdata = 1'b1;
                    n_kept = r_kept + 1'b1;
                    n_j = '0;
                    n_have = 1'b0;
                    n_state = ST_EM_RD;
                end
            end
            ST_DONE: begin
                if (o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bin_w   <= BIN_RESET;
            r_bin_h   <= BIN_RESET;
            r_whole_w <= BIN_RESET;
            r_whole_h <= BIN_RESET;
            r_fresh   <= 1'b1;
            r_total   <= TOT_W'(1);
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_total <= n_total;
            if (i_cfg_we && i_cfg_idx == CFG_BIN_WIDTH) begin
                r_bin_w <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_idx == CFG_BIN_HEIGHT) begin
                r_bin_h <= i_cfg_wdata;
            end
            if (r_state == ST_IDLE && i_req.valid && i_req.action == ACT_NEW_BIN) begin
                r_whole_w <= r_bin_w;
                r_whole_h <= r_bin_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw <= n_pw;       r_ph <= n_ph;
        r_i <= n_i;         r_j <= n_j;         r_n <= n_n;     r_p <= n_p;
        r_found <= n_found; r_best <= n_best;   r_bw <= n_bw;   r_bh <= n_bh;
        r_px <= n_px;       r_py <= n_py;       r_qx <= n_qx;   r_qy <= n_qy;
        r_bt <= n_bt;       r_f <= n_f;         r_bi <= n_bi;   r_drop <= n_drop;
        r_area <= n_area;   r_best_area <= n_best_area;         r_mk <= n_mk;
        r_best_idx <= n_best_idx; r_have <= n_have; r_kept <= n_kept; r_lost <= n_lost;
        r_placed <= n_placed; r_turned <= n_turned; r_ovf <= n_ovf;
        r_pos_x <= n_pos_x; r_pos_y <= n_pos_y; r_count <= n_count;
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = (r_state == ST_DONE);
    assign o_res.placed     = r_placed;
    assign o_res.pos_x      = r_pos_x;
    assign o_res.pos_y      = r_pos_y;
    assign o_res.turned     = r_turned;
    assign o_res.free_count = r_count;
    assign o_res.overflow   = r_ovf;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_res.valid))
        else $error("request and result sides active together");

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(MAX_FREE))
        else $error("free list count beyond capacity");

    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.placed) |->
            (o_res.pos_x == '0 && o_res.pos_y == '0 && !o_res.turned && !o_res.overflow))
        else $error("unplaced result carries placement data");

    a_new_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.action == ACT_NEW_BIN) |=>
            (o_res.valid && o_res.free_count == TOT_W'(1)))
        else $error("new bin result missing");
endmodule
`default_nettype wire
